>>> hw/rtl/pulse_width_remote_decoder_assert.svh
// ---------------------------------------------------------------------------
// Pulse width remote decoder assertion macros
// Short wrappers for the concurrent checks of the decoder top level.
// ---------------------------------------------------------------------------
`ifndef PULSE_WIDTH_REMOTE_DECODER_ASSERT_SVH
`define PULSE_WIDTH_REMOTE_DECODER_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define PWRD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define PWRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pwrd_pkg.sv
// ---------------------------------------------------------------------------
// Pulse width remote decoder package
// Shared types, register indexes and constants of the decoder.
// ---------------------------------------------------------------------------
package pwrd_pkg;

   localparam int HEADER_FACTOR = 36;
   localparam int GAP_FACTOR    = 4;
   localparam int HDR_BITS      = 22;
   localparam int GAP_BITS      = 18;
   localparam int CSR_BITS      = 16;
   localparam int COUNT_BITS    = 7;
   localparam int CODE_BITS     = 64;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = 7'd64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int FILL_BITS   = 3;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_SHORT_PERIOD = 2'd0;
   localparam logic [1:0] REG_LONG_PERIOD  = 2'd1;
   localparam logic [1:0] REG_TOLERANCE    = 2'd2;
   localparam logic [1:0] REG_MIN_BITS     = 2'd3;

   localparam logic [CSR_BITS-1:0]   SHORT_RESET    = 16'd700;
   localparam logic [CSR_BITS-1:0]   LONG_RESET     = 16'd1400;
   localparam logic [CSR_BITS-1:0]   TOL_RESET      = 16'd200;
   localparam logic [COUNT_BITS-1:0] MIN_BITS_RESET = 7'd12;
   localparam logic [HDR_BITS-1:0]   SHORT_X36_RESET = HDR_BITS'(700 * HEADER_FACTOR);
   localparam logic [HDR_BITS-1:0]   TOL_X36_RESET   = HDR_BITS'(200 * HEADER_FACTOR);
   localparam logic [GAP_BITS-1:0]   SHORT_X4_RESET  = GAP_BITS'(700 * GAP_FACTOR);

   typedef enum logic [1:0] {
      STEP_SEARCH,
      STEP_START,
      STEP_LOW,
      STEP_HIGH
   } step_type;

   // Timing settings as the classifier sees them, with scaled copies.
   typedef struct packed {
      logic [CSR_BITS-1:0] short_period;
      logic [CSR_BITS-1:0] long_period;
      logic [CSR_BITS-1:0] tolerance;
      logic [HDR_BITS-1:0] short_x36;
      logic [HDR_BITS-1:0] tol_x36;
      logic [GAP_BITS-1:0] short_x4;
   } cfg_type;

   // One classified pulse.
   typedef struct packed {
      logic level;
      logic header;
      logic short_hit;
      logic long_hit;
      logic gap;
   } class_type;

endpackage

>>> hw/rtl/pulse_width_remote_decoder.sv
// ---------------------------------------------------------------------------
// Pulse width remote decoder
// Decodes pulse-width coded remote frames from a stream of timed pulses.
// ---------------------------------------------------------------------------
// The decoder takes one pulse beat (level and duration in microseconds) per
// clock cycle and reports one beat per complete frame with the received code
// and its bit count. A front end compares each duration against the header,
// short, long and gap timings and writes the outcome into a four-entry queue;
// a back end runs the frame state machine from that queue and loads a result
// register. Both sides keep moving at one beat per cycle as long as the result
// side is not stalled; a pulse that ends a frame passes through the queue
// and then the result register before its beat reaches the result port.
// While a result beat waits under stall the queue keeps taking pulses until
// it holds four, and then the input stalls. The timing registers must be
// written only while the decoder is idle; the block does not enforce this.
// The scaled header and gap thresholds are formed when a register is
// written, so a pulse costs a single subtract and compare per timing.
`include "pulse_width_remote_decoder_assert.svh"

module pulse_width_remote_decoder
   import pwrd_pkg::*;
#(
   parameter int DURATION_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_level,
   input  logic [DURATION_BITS-1:0] req_duration,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CODE_BITS-1:0]     rsp_code,
   output logic [COUNT_BITS-1:0]    rsp_bit_count,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_BITS-1:0]      csr_data
);

   // Timing registers and their scaled copies.
   cfg_type                 cfg_ff;
   logic [COUNT_BITS-1:0]   min_bits_ff;
   logic [HDR_BITS-1:0]     data_x36;
   logic [HDR_BITS-1:0]     data_wide;

   logic      push;
   class_type push_entry;
   logic      q_full;
   logic      q_valid;
   class_type q_entry;
   logic      pop;

   // Times 36 is times 32 plus times 4.
   assign data_wide = {{(HDR_BITS-CSR_BITS){1'b0}}, csr_data};
   assign data_x36  = (data_wide << 5) + (data_wide << 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_period <= SHORT_RESET;
         cfg_ff.long_period  <= LONG_RESET;
         cfg_ff.tolerance    <= TOL_RESET;
         cfg_ff.short_x36    <= SHORT_X36_RESET;
         cfg_ff.tol_x36      <= TOL_X36_RESET;
         cfg_ff.short_x4     <= SHORT_X4_RESET;
         min_bits_ff         <= MIN_BITS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SHORT_PERIOD: begin
               cfg_ff.short_period <= csr_data;
               cfg_ff.short_x36    <= data_x36;
               cfg_ff.short_x4     <= {csr_data, 2'b00};
            end
            REG_LONG_PERIOD: begin
               cfg_ff.long_period <= csr_data;
            end
            REG_TOLERANCE: begin
               cfg_ff.tolerance <= csr_data;
               cfg_ff.tol_x36   <= data_x36;
            end
            REG_MIN_BITS: begin
               min_bits_ff <= csr_data[COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   pwrd_front #(
      .DURATION_BITS(DURATION_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_level   (req_level),
      .req_duration(req_duration),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   pwrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_entry   (q_entry)
   );

   pwrd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .pop          (pop),
      .min_bits     (min_bits_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_code     (rsp_code),
      .rsp_bit_count(rsp_bit_count)
   );

   // A full queue is never empty, so a stalled input always has work behind it.
   `PWRD_ASSERT_SAME(a_stall_has_work, clock, reset, req_stall, q_valid, "input stalled with an empty queue")

   // A new result beat only follows a pulse taken from the queue.
   `PWRD_ASSERT_NEXT(a_result_from_pop, clock, reset, (!rsp_valid || !rsp_stall) && !pop, !rsp_valid, "result beat without a pulse")

   // The reported bit count saturates at the register width of the code.
   `PWRD_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, rsp_bit_count <= MAX_COUNT, "bit count above limit")

endmodule

>>> hw/rtl/pwrd_front.sv
// ---------------------------------------------------------------------------
// Pulse width remote decoder front end
// Accepts pulse beats and classifies each duration against the timings.
// ---------------------------------------------------------------------------
module pwrd_front
   import pwrd_pkg::*;
#(
   parameter int DURATION_BITS = 24
) (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_level,
   input  logic [DURATION_BITS-1:0] req_duration,
   input  cfg_type                  cfg,
   input  logic                     q_full,
   output logic                     push,
   output class_type                push_entry
);

   localparam int CW = ((DURATION_BITS > HDR_BITS) ? DURATION_BITS : HDR_BITS) + 1;

   function automatic logic near(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                 input logic [CW-1:0] tol);
      logic [CW-1:0] diff;
      begin
         diff = (a > b) ? (a - b) : (b - a);
         near = (diff < tol);
      end
   endfunction

   logic [CW-1:0] dur;
   logic [CW-1:0] short_w;
   logic [CW-1:0] long_w;
   logic [CW-1:0] tol_w;
   logic [CW-1:0] short36_w;
   logic [CW-1:0] tol36_w;
   logic [CW-1:0] short4_w;

   assign dur       = {{(CW-DURATION_BITS){1'b0}}, req_duration};
   assign short_w   = {{(CW-CSR_BITS){1'b0}}, cfg.short_period};
   assign long_w    = {{(CW-CSR_BITS){1'b0}}, cfg.long_period};
   assign tol_w     = {{(CW-CSR_BITS){1'b0}}, cfg.tolerance};
   assign short36_w = {{(CW-HDR_BITS){1'b0}}, cfg.short_x36};
   assign tol36_w   = {{(CW-HDR_BITS){1'b0}}, cfg.tol_x36};
   assign short4_w  = {{(CW-GAP_BITS){1'b0}}, cfg.short_x4};

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_entry.level     = req_level;
      push_entry.header    = near(dur, short36_w, tol36_w);
      push_entry.short_hit = near(dur, short_w, tol_w);
      push_entry.long_hit  = near(dur, long_w, tol_w);
      push_entry.gap       = (dur >= short4_w);
   end

endmodule

>>> hw/rtl/pwrd_queue.sv
// ---------------------------------------------------------------------------
// Pulse width remote decoder queue
// Small first-in first-out buffer of classified pulses between the halves.
// ---------------------------------------------------------------------------
module pwrd_queue
   import pwrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      q_valid,
   output class_type q_entry
);

   class_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;

   assign full    = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign q_valid = (fill_ff != '0);
   assign q_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/pwrd_back.sv
// ---------------------------------------------------------------------------
// Pulse width remote decoder back end
// Frame state machine, code shift register and registered result beat.
// ---------------------------------------------------------------------------
module pwrd_back
   import pwrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  class_type             q_entry,
   output logic                  pop,
   input  logic [COUNT_BITS-1:0] min_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_BITS-1:0]  rsp_code,
   output logic [COUNT_BITS-1:0] rsp_bit_count
);

   step_type                step_ff, step_in;
   logic [CODE_BITS-1:0]    code_ff, code_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    low_short_ff, low_short_in;
   logic                    low_long_ff, low_long_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]    rsp_code_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;

   logic clear_frame;
   logic push_zero;
   logic push_one;
   logic latch_low;
   logic emit;

   assign pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      step_in = step_ff;
      if (pop) begin
         unique case (step_ff)
            STEP_SEARCH: begin
               step_in = (!q_entry.level && q_entry.header) ? STEP_START : STEP_SEARCH;
            end
            STEP_START: begin
               if (q_entry.level) begin
                  step_in = q_entry.short_hit ? STEP_LOW : STEP_SEARCH;
               end
            end
            STEP_LOW: begin
               if (q_entry.level) begin
                  step_in = STEP_SEARCH;
               end else begin
                  step_in = q_entry.gap ? STEP_START : STEP_HIGH;
               end
            end
            STEP_HIGH: begin
               if (q_entry.level && ((low_short_ff && q_entry.long_hit) ||
                                     (low_long_ff && q_entry.short_hit))) begin
                  step_in = STEP_LOW;
               end else begin
                  step_in = STEP_SEARCH;
               end
            end
            default: step_in = STEP_SEARCH;
         endcase
      end
   end

   always_comb begin
      clear_frame = 1'b0;
      push_zero   = 1'b0;
      push_one    = 1'b0;
      latch_low   = 1'b0;
      emit        = 1'b0;
      if (pop) begin
         unique case (step_ff)
            STEP_SEARCH: begin
            end
            STEP_START: begin
               clear_frame = q_entry.level && q_entry.short_hit;
            end
            STEP_LOW: begin
               latch_low = !q_entry.level && !q_entry.gap;
               emit      = !q_entry.level && q_entry.gap && (count_ff >= min_bits);
            end
            STEP_HIGH: begin
               // The zero pattern wins when both patterns match.
               push_zero = q_entry.level && low_short_ff && q_entry.long_hit;
               push_one  = q_entry.level && !push_zero && low_long_ff && q_entry.short_hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      code_in      = code_ff;
      count_in     = count_ff;
      low_short_in = low_short_ff;
      low_long_in  = low_long_ff;
      if (clear_frame) begin
         code_in  = '0;
         count_in = '0;
      end else if (push_zero || push_one) begin
         code_in  = {code_ff[CODE_BITS-2:0], push_one};
         count_in = (count_ff == MAX_COUNT) ? count_ff : (count_ff + 1'b1);
      end
      if (latch_low) begin
         low_short_in = q_entry.short_hit;
         low_long_in  = q_entry.long_hit;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_SEARCH;
         code_ff      <= '0;
         count_ff     <= '0;
         low_short_ff <= 1'b0;
         low_long_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         code_ff      <= code_in;
         count_ff     <= count_in;
         low_short_ff <= low_short_in;
         low_long_ff  <= low_long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_code_ff  <= code_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_bit_count = rsp_count_ff;

endmodule

>>> dv/pwrd_frame_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pulse width remote decoder frame checker
// Watches the pulse, result and register ports of the decoder, decodes the
// accepted pulses on its own and compares every result beat with the oldest
// frame that it expects.
// ---------------------------------------------------------------------------
module pwrd_frame_checker
   import pwrd_pkg::*;
#(
   parameter int DURATION_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_level,
   input  logic [DURATION_BITS-1:0] req_duration,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [CODE_BITS-1:0]     rsp_code,
   input  logic [COUNT_BITS-1:0]    rsp_bit_count,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_BITS-1:0]      csr_data,
   output int                       mismatches,
   output int                       frames_pending,
   output int                       pulses_taken
);

   localparam int HEADER_SCALE = 36;
   localparam int GAP_SCALE    = 4;
   localparam logic [COUNT_BITS-1:0] COUNT_CAP   = 7'd64;
   localparam logic [CSR_BITS-1:0]   DEFAULT_SHORT = 16'd700;
   localparam logic [CSR_BITS-1:0]   DEFAULT_LONG  = 16'd1400;
   localparam logic [CSR_BITS-1:0]   DEFAULT_TOL   = 16'd200;
   localparam logic [COUNT_BITS-1:0] DEFAULT_MIN   = 7'd12;

   typedef struct packed {
      logic [CODE_BITS-1:0]  code;
      logic [COUNT_BITS-1:0] bit_count;
   } frame_type;

   logic [CSR_BITS-1:0]      short_p;
   logic [CSR_BITS-1:0]      long_p;
   logic [CSR_BITS-1:0]      tol;
   logic [COUNT_BITS-1:0]    min_bits;
   step_type                 step;
   logic [CODE_BITS-1:0]     code_acc;
   logic [COUNT_BITS-1:0]    nbits;
   logic [DURATION_BITS-1:0] last_low;
   frame_type                pending_frames[$];
   frame_type                oldest;
   int                       errors;
   int                       taken;

   function automatic bit close_to(longint unsigned a, longint unsigned b,
                                   longint unsigned window);
      longint unsigned delta;
      delta = (a > b) ? a - b : b - a;
      return delta < window;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
   endtask

   task automatic shift_in(input logic b);
      code_acc = {code_acc[CODE_BITS-2:0], b};
      if (nbits < COUNT_CAP)
         nbits++;
   endtask

   // Runs one pulse through the frame machine and queues the frame it closes.
   task automatic decode_pulse(input logic lvl, input logic [DURATION_BITS-1:0] dur_in);
      longint unsigned dur, sp, lp, tl;
      frame_type fr;
      dur = dur_in;
      sp  = short_p;
      lp  = long_p;
      tl  = tol;
      case (step)
         STEP_SEARCH: begin
            if (!lvl && close_to(dur, sp * HEADER_SCALE, tl * HEADER_SCALE))
               step = STEP_START;
         end
         STEP_START: begin
            if (lvl) begin
               if (close_to(dur, sp, tl)) begin
                  step     = STEP_LOW;
                  code_acc = '0;
                  nbits    = '0;
               end else begin
                  step = STEP_SEARCH;
               end
            end
         end
         STEP_LOW: begin
            if (lvl) begin
               step = STEP_SEARCH;
            end else if (dur >= sp * GAP_SCALE) begin
               step = STEP_START;
               if (nbits >= min_bits) begin
                  fr.code      = code_acc;
                  fr.bit_count = nbits;
                  pending_frames.push_back(fr);
               end
            end else begin
               last_low = dur_in;
               step     = STEP_HIGH;
            end
         end
         default: begin
            // The zero pattern wins when both patterns match.
            if (lvl && close_to(last_low, sp, tl) && close_to(dur, lp, tl)) begin
               shift_in(1'b0);
               step = STEP_LOW;
            end else if (lvl && close_to(last_low, lp, tl) && close_to(dur, sp, tl)) begin
               shift_in(1'b1);
               step = STEP_LOW;
            end else begin
               step = STEP_SEARCH;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         short_p  = DEFAULT_SHORT;
         long_p   = DEFAULT_LONG;
         tol      = DEFAULT_TOL;
         min_bits = DEFAULT_MIN;
         step     = STEP_SEARCH;
         code_acc = '0;
         nbits    = '0;
         last_low = '0;
         pending_frames.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_SHORT_PERIOD: short_p  = csr_data;
               REG_LONG_PERIOD:  long_p   = csr_data;
               REG_TOLERANCE:    tol      = csr_data;
               REG_MIN_BITS:     min_bits = csr_data[COUNT_BITS-1:0];
            endcase
         end
         if (req_valid && !req_stall) begin
            decode_pulse(req_level, req_duration);
            taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_frames.size() == 0) begin
               report_mismatch("unexpected result beat", '0, rsp_code);
            end else begin
               oldest = pending_frames.pop_front();
               if (rsp_code !== oldest.code)
                  report_mismatch("code", oldest.code, rsp_code);
               if (rsp_bit_count !== oldest.bit_count)
                  report_mismatch("bit_count", 64'(oldest.bit_count), 64'(rsp_bit_count));
            end
         end
      end
      mismatches     <= errors;
      frames_pending <= pending_frames.size();
      pulses_taken   <= taken;
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pulse width remote decoder testbench
// Drives timed pulses into the decoder under a series of timing settings and
// lets the frame checker compare every reported frame with its own decoding.
// ---------------------------------------------------------------------------
module tb;
   import pwrd_pkg::*;

   localparam int DUR_BITS      = 24;
   localparam longint DUR_MAX   = (64'd1 << DUR_BITS) - 1;
   localparam int HEADER_SCALE  = 36;
   localparam int GAP_SCALE     = 4;
   localparam int TOTAL_PULSES  = 2000;
   localparam int PHASE_PULSES  = 200;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int LIMIT_CYCLES  = 1000000;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   logic                    req_level     = 1'b0;
   logic [DUR_BITS-1:0]     req_duration  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic [CODE_BITS-1:0]    rsp_code;
   logic [COUNT_BITS-1:0]   rsp_bit_count;
   logic                    csr_write     = 1'b0;
   logic [1:0]              csr_index     = REG_SHORT_PERIOD;
   logic [CSR_BITS-1:0]     csr_data      = '0;

   int mismatches;
   int frames_pending;
   int pulses_taken;

   // Timing that the stimulus aims at; it follows every register write.
   int cur_short = 700;
   int cur_long  = 1400;
   int cur_tol   = 200;
   int cur_min   = 12;

   int pulses_sent = 0;
   int cycle_count = 0;
   bit no_gaps     = 1'b0;  // a frame sent back to back, without sender gaps
   bit rsp_quiet   = 1'b0;  // keeps the receiver ready while the decoder drains
   bit held_off    = 1'b0;

   pulse_width_remote_decoder #(.DURATION_BITS(DUR_BITS)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_level     (req_level),
      .req_duration  (req_duration),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code      (rsp_code),
      .rsp_bit_count (rsp_bit_count),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   pwrd_frame_checker #(.DURATION_BITS(DUR_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_level      (req_level),
      .req_duration   (req_duration),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code       (rsp_code),
      .rsp_bit_count  (rsp_bit_count),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .frames_pending (frames_pending),
      .pulses_taken   (pulses_taken)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is bounded; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side. Each pass picks a stall level and how many cycles it holds.
   // Most runs are short, a few are long, and some are long stretches with no
   // stall at all. Once, while a frame is on its way, the receiver holds off
   // for a long time so that the pulse queue fills and the input stalls.
   initial begin : receiver
      int pick;
      int run_len;
      bit stall_val;
      forever begin
         pick = $urandom_range(0, 99);
         if (rsp_quiet) begin
            stall_val = 1'b0;
            run_len   = 1;
         end else if (!held_off && frames_pending > 0 && pulses_taken > 300) begin
            held_off  = 1'b1;
            stall_val = 1'b1;
            run_len   = LONG_HOLD;
         end else if (pick < 55) begin
            stall_val = 1'b0;
            run_len   = $urandom_range(1, 4);
         end else if (pick < 85) begin
            stall_val = 1'b1;
            run_len   = $urandom_range(1, 3);
         end else if (pick < 93) begin
            stall_val = 1'b0;
            run_len   = $urandom_range(30, 80);
         end else begin
            stall_val = 1'b1;
            run_len   = $urandom_range(10, 30);
         end
         rsp_stall <= stall_val;
         repeat (run_len) @(posedge clock);
      end
   end

   // Sender gaps: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 60)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [DUR_BITS-1:0] clip_duration(longint v);
      if (v < 0)
         return '0;
      if (v > DUR_MAX)
         return DUR_MAX[DUR_BITS-1:0];
      return v[DUR_BITS-1:0];
   endfunction

   // A duration inside the match window around a nominal length, with the
   // window edges favored. With misses allowed it may land just outside.
   function automatic logic [DUR_BITS-1:0] pulse_near(longint nominal, longint spread,
                                                      bit may_miss);
      int pick;
      longint v;
      pick = $urandom_range(0, 9);
      if (spread <= 0)
         v = nominal;
      else if (may_miss && pick < 3)
         v = $urandom_range(0, 1) ? nominal + spread : nominal - spread;
      else if (pick == 3)
         v = nominal + spread - 1;
      else if (pick == 4)
         v = nominal - (spread - 1);
      else
         v = nominal - (spread - 1) + longint'($urandom_range(0, int'(2 * (spread - 1))));
      return clip_duration(v);
   endfunction

   function automatic logic [DUR_BITS-1:0] random_duration();
      int pick;
      longint sp, tl;
      sp   = cur_short;
      tl   = cur_tol;
      pick = $urandom_range(0, 5);
      case (pick)
         0, 1: return DUR_BITS'($urandom);
         2:    return pulse_near(sp * HEADER_SCALE, tl * HEADER_SCALE, 1'b1);
         3:    return pulse_near(longint'(cur_long), tl, 1'b1);
         4:    return pulse_near(sp, tl, 1'b1);
         default: return clip_duration(longint'($urandom_range(0, cur_short * 5 + 10)));
      endcase
   endfunction

   function automatic int pick_bits();
      int pick;
      int n;
      pick = $urandom_range(0, 19);
      if (pick < 11)
         return $urandom_range(0, 20);
      if (pick < 17) begin
         n = cur_min + int'($urandom_range(0, 4)) - 2;
         return (n < 0) ? 0 : (n > 64) ? 64 : n;
      end
      return $urandom_range(60, 72);
   endfunction

   // Offers one pulse beat and returns at the edge that takes it.
   task automatic send_pulse(input logic lvl, input logic [DUR_BITS-1:0] dur);
      int gap_len;
      gap_len = pick_gap();
      if (gap_len > 0) begin
         req_valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_level    <= lvl;
      req_duration <= dur;
      do
         @(posedge clock);
      while (req_stall);
      pulses_sent++;
   endtask

   // One frame: header, start bit, bit pairs and the closing gap. A spoiled
   // frame carries one random pulse somewhere among its bits.
   task automatic send_frame(input int nbits, input bit with_header, input bit spoil);
      int spoil_at;
      int i;
      longint sp, lp, tl, gap_dur;
      sp       = cur_short;
      lp       = cur_long;
      tl       = cur_tol;
      spoil_at = spoil ? int'($urandom_range(0, nbits)) : -1;
      no_gaps  = ($urandom_range(0, 3) == 0);
      if (with_header)
         send_pulse(1'b0, pulse_near(sp * HEADER_SCALE, tl * HEADER_SCALE, 1'b0));
      // A low pulse while waiting for the start bit must be ignored.
      if ($urandom_range(0, 7) == 0)
         send_pulse(1'b0, random_duration());
      send_pulse(1'b1, pulse_near(sp, tl, 1'b0));
      for (i = 0; i < nbits; i++) begin
         if (i == spoil_at)
            send_pulse(1'($urandom_range(0, 1)), random_duration());
         if ($urandom_range(0, 1)) begin
            send_pulse(1'b0, pulse_near(lp, tl, 1'b0));
            send_pulse(1'b1, pulse_near(sp, tl, 1'b0));
         end else begin
            send_pulse(1'b0, pulse_near(sp, tl, 1'b0));
            send_pulse(1'b1, pulse_near(lp, tl, 1'b0));
         end
      end
      if (spoil_at == nbits)
         send_pulse(1'($urandom_range(0, 1)), random_duration());
      case ($urandom_range(0, 7))
         0:       gap_dur = sp * GAP_SCALE;
         1:       gap_dur = DUR_MAX;
         default: gap_dur = sp * GAP_SCALE + longint'($urandom_range(0, cur_short * 4));
      endcase
      send_pulse(1'b0, clip_duration(gap_dur));
      no_gaps = 1'b0;
   endtask

   // Stops offering pulses and waits until every expected frame has come out
   // and the pulse queue has had time to empty. The first edge lets the
   // checker's count take in the last accepted pulse.
   task automatic quiesce();
      rsp_quiet = 1'b1;
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timing(input int sp, input int lp, input int tl, input int mb);
      cur_short = sp;
      cur_long  = lp;
      cur_tol   = tl;
      cur_min   = mb;
      csr_write <= 1'b1;
      csr_index <= REG_SHORT_PERIOD;
      csr_data  <= CSR_BITS'(sp);
      @(posedge clock);
      csr_index <= REG_LONG_PERIOD;
      csr_data  <= CSR_BITS'(lp);
      @(posedge clock);
      csr_index <= REG_TOLERANCE;
      csr_data  <= CSR_BITS'(tl);
      @(posedge clock);
      csr_index <= REG_MIN_BITS;
      csr_data  <= CSR_BITS'(mb);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // The first phases cover fixed corners: the reset timing, the smallest
   // periods with exact matching and reporting of empty frames, the largest
   // values everywhere, zero tolerance where nothing can match, a minimum
   // length that no frame reaches, a long period below the short one, and a
   // tolerance wide enough that everything matches. Later phases pick a
   // sensible random timing, and now and then fully random register values.
   task automatic run_phase(input int idx);
      int quota;
      int kind;
      int sp;
      quiesce();
      case (idx)
         0: write_timing(700, 1400, 200, 12);
         1: write_timing(1, 2, 1, 0);
         2: write_timing(65535, 65535, 65535, 64);
         3: write_timing(900, 1800, 0, 1);
         4: write_timing(500, 1000, 150, 127);
         5: write_timing(1200, 400, 300, 64);
         6: write_timing(300, 900, 65535, 1);
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               write_timing($urandom_range(1, 65535), $urandom_range(1, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 127));
            end else begin
               sp = $urandom_range(40, 3000);
               write_timing(sp, sp * int'($urandom_range(2, 4)),
                            $urandom_range(1, sp / 2), $urandom_range(1, 40));
            end
         end
      endcase
      rsp_quiet = 1'b0;
      quota = pulses_sent + PHASE_PULSES;
      while (pulses_sent < quota) begin
         kind = $urandom_range(0, 9);
         if (kind < 6)
            send_frame(pick_bits(), 1'b1, 1'b0);
         else if (kind < 7)
            send_frame(pick_bits(), 1'b0, 1'b0);  // repeat frame right after a gap
         else if (kind < 8)
            send_frame(pick_bits(), 1'b1, 1'b1);
         else
            repeat ($urandom_range(1, 4))
               send_pulse(1'($urandom_range(0, 1)), random_duration());
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset timing: 700 short, 1400 long,
      // 200 tolerance, so the header window is 25200 plus or minus 7199.
      send_pulse(1'b0, '0);                        // shortest pulse, no header
      send_pulse(1'b1, DUR_MAX[DUR_BITS-1:0]);     // longest pulse
      send_pulse(1'b0, 24'(25200 + 7199));         // header at its upper edge
      send_pulse(1'b0, 24'd3);                     // low before start is ignored
      send_pulse(1'b1, 24'(700 - 199));            // start bit at its lower edge
      send_pulse(1'b0, 24'd700);                   // a zero
      send_pulse(1'b1, 24'd1400);
      send_pulse(1'b0, 24'd1400);                  // a one
      send_pulse(1'b1, 24'd700);
      send_pulse(1'b0, 24'd899);                   // a zero at the window edges
      send_pulse(1'b1, 24'd1599);
      send_pulse(1'b0, 24'd1201);                  // a one at the window edges
      send_pulse(1'b1, 24'd501);
      send_pulse(1'b0, 24'd2799);                  // just short of a frame gap
      send_pulse(1'b1, 24'd700);                   // pair matches nothing
      send_pulse(1'b0, 24'(25200 - 7200));         // header just outside
      send_pulse(1'b0, 24'(25200 - 7199));         // header at its lower edge
      send_pulse(1'b1, 24'd700);
      send_pulse(1'b1, 24'd700);                   // high where a low is due
      send_pulse(1'b0, 24'd25200);
      send_pulse(1'b1, 24'd700);
      send_pulse(1'b0, 24'd700);
      send_pulse(1'b0, 24'd700);                   // low where a high is due
      send_pulse(1'b0, 24'd25200);
      send_pulse(1'b1, 24'd700);
      send_pulse(1'b0, 24'd2800);                  // empty frame, gap at its edge

      phase = 0;
      while (pulses_sent < TOTAL_PULSES) begin
         run_phase(phase);
         phase++;
      end

      quiesce();
      if (mismatches == 0 && frames_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
